>>> rtl/core/tbp_pkg.sv
// Shared types and constants for the token bucket policer.
// Used by the controller, the datapath and the top level; no dependencies.
package tbp_pkg;

    // Client slot store.
    localparam int CLIENTS  = 256;
    localparam int SLOT_W   = $clog2(CLIENTS);
    localparam int CLIENT_W = 8;

    // Field and register widths.
    localparam int TIME_W    = 32;
    localparam int RATE_W    = 16;
    localparam int BURST_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Bucket levels are kept in units of 1/60 token.
    localparam int LEVEL_W         = 22;
    localparam int UNITS_PER_TOKEN = 60;
    localparam int PROD_W          = TIME_W + RATE_W;
    localparam int SUM_W           = PROD_W + 1;

    // One RAM word holds the last refill time above the bucket level.
    localparam int RAM_W = TIME_W + LEVEL_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REG_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_BURST = 1'b1;

    // Register values after reset.
    localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd600;
    localparam logic [BURST_W-1:0] BURST_RESET = 16'd50;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read_step;
        logic mul_step;
        logic sum_step;
        logic commit;
    } tbp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } tbp_status_t;

endpackage

>>> rtl/core/tbp_ram.sv
// Generic single-port RAM with a registered read.
// Stand-alone; holds the bucket level and refill time of each slot.
module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: write, or read into the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tbp_ctrl.sv
// Sequencing controller of the token bucket policer.
// Depends on tbp_pkg for the command and status structs.
module tbp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tbp_pkg::tbp_status_t status,
    output tbp_pkg::tbp_cmd_t    cmd
);
    import tbp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_DEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state: one step per cycle, and the decision waits for a free
    // output register.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_DEC;
            ST_DEC:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands decoded from the state.
    assign in_ready      = (state_reg == ST_IDLE);
    assign cmd.load      = (state_reg == ST_IDLE) && in_valid;
    assign cmd.read_step = (state_reg == ST_READ);
    assign cmd.mul_step  = (state_reg == ST_MUL);
    assign cmd.sum_step  = (state_reg == ST_SUM);
    assign cmd.commit    = (state_reg == ST_DEC) && !status.out_full;

endmodule

>>> rtl/core/tbp_dp.sv
// Datapath of the token bucket policer: configuration, slot store,
// refill arithmetic and the output register.
// Depends on tbp_pkg and tbp_ram.
module tbp_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]       cfg_data,
    input  logic [tbp_pkg::CLIENT_W-1:0]    client,
    input  logic [tbp_pkg::TIME_W-1:0]      now_seconds,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            allowed,
    input  tbp_pkg::tbp_cmd_t               cmd,
    output tbp_pkg::tbp_status_t            status
);
    import tbp_pkg::*;

    // Configuration and control state.
    logic [RATE_W-1:0]  rate_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [CLIENTS-1:0] slot_valid_reg;
    logic [CLIENTS-1:0] slot_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // Payload registers of the item in flight.
    logic [SLOT_W-1:0]  slot_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               fresh_reg;
    logic               fresh_next;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [TIME_W-1:0]  elapsed_next;
    logic [LEVEL_W-1:0] old_level_reg;
    logic [LEVEL_W-1:0] old_level_next;
    logic [PROD_W-1:0]  product_reg;
    logic [PROD_W-1:0]  product_next;
    logic [LEVEL_W-1:0] cap_reg;
    logic [LEVEL_W-1:0] cap_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               allowed_reg;

    // Slot store signals.
    logic               ram_en;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_addr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;
    logic [TIME_W-1:0]  last_time;
    logic [LEVEL_W-1:0] stored_level;
    logic               slot_hit;
    logic [SUM_W-1:0]   sum;
    logic               take;
    logic [LEVEL_W-1:0] new_level;

    // The store is read when an item is taken in and written when a token
    // is taken; the two never fall in the same cycle.
    assign take      = level_reg >= LEVEL_W'(UNITS_PER_TOKEN);
    assign new_level = level_reg - LEVEL_W'(UNITS_PER_TOKEN);
    assign ram_en    = cmd.load || (cmd.commit && take);
    assign ram_we    = cmd.commit && take;
    assign ram_addr  = cmd.load ? client[SLOT_W-1:0] : slot_reg;
    assign ram_wdata = {now_reg, new_level};

    tbp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CLIENTS)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Read step: elapsed time, clamped at zero when time runs backwards.
    // A slot never used takes the full bucket and ignores the store data.
    assign last_time    = ram_rdata[RAM_W-1:LEVEL_W];
    assign stored_level = ram_rdata[LEVEL_W-1:0];
    assign slot_hit     = slot_valid_reg[slot_reg];

    always_comb
    begin
        fresh_next     = !slot_hit;
        old_level_next = slot_hit ? stored_level : '0;
        if (slot_hit && (now_reg > last_time))
        begin
            elapsed_next = now_reg - last_time;
        end
        else
        begin
            elapsed_next = '0;
        end
    end

    // Multiply step: refill in 1/60 token and the capacity in the same units.
    assign product_next = PROD_W'(elapsed_reg) * PROD_W'(rate_reg);
    assign cap_next     = LEVEL_W'(burst_reg) * LEVEL_W'(UNITS_PER_TOKEN);

    // Sum step: add the refill and saturate at the capacity.
    assign sum = SUM_W'(old_level_reg) + SUM_W'(product_reg);

    always_comb
    begin
        if (fresh_reg || (sum > SUM_W'(cap_reg)))
        begin
            level_next = cap_reg;
        end
        else
        begin
            level_next = sum[LEVEL_W-1:0];
        end
    end

    // Slot used flags and output valid.
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (cmd.commit && take)
        begin
            slot_valid_next[slot_reg] = 1'b1;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg       <= RATE_RESET;
            burst_reg      <= BURST_RESET;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_REG_RATE:  rate_reg  <= cfg_data[RATE_W-1:0];
                    CFG_REG_BURST: burst_reg <= cfg_data[BURST_W-1:0];
                    default:       rate_reg  <= rate_reg;
                endcase
            end
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload pipeline of the item in flight.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot_reg <= client[SLOT_W-1:0];
            now_reg  <= now_seconds;
        end
        if (cmd.read_step)
        begin
            fresh_reg     <= fresh_next;
            elapsed_reg   <= elapsed_next;
            old_level_reg <= old_level_next;
        end
        if (cmd.mul_step)
        begin
            product_reg <= product_next;
            cap_reg     <= cap_next;
        end
        if (cmd.sum_step)
        begin
            level_reg <= level_next;
        end
        if (cmd.commit)
        begin
            allowed_reg <= take;
        end
    end

    assign status.out_full = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign allowed         = allowed_reg;

endmodule

>>> rtl/core/token_bucket_policer.sv
// Top level of the token bucket policer.
// Depends on tbp_pkg, tbp_ctrl, tbp_dp and tbp_ram.
//
// Usage:
// Each input transfer carries a client slot and the current time in whole
// seconds. Each one yields exactly one output transfer whose allowed bit
// says whether a token was taken from that slot's bucket.
// Both channels use valid/ready. The configuration port writes the refill
// rate (index 0) and the burst size (index 1); write it only
// while no request is in flight.
// Requests are handled one at a time: a new one is taken only once the
// last has passed the read, multiply, sum and decide steps.
// The output register lets the next request be taken in while a result
// still waits; a receiver stall holds the decision step only once a second
// result is ready.
// Reset restores the rate to 600 and the burst size to 50 and marks all
// slots unused at once, so no clearing pass is needed.
module token_bucket_policer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tbp_pkg::CLIENT_W-1:0]    client,
    input  logic [tbp_pkg::TIME_W-1:0]      now_seconds,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            allowed
);
    import tbp_pkg::*;

    tbp_cmd_t    cmd;
    tbp_status_t status;

    // Step sequencer.
    tbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Bucket arithmetic, slot store and output register.
    tbp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .client       (client),
        .now_seconds  (now_seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .allowed      (allowed),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

>>> tb/token_bucket_policer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for token_bucket_policer: directed and random requests
// against an in-bench bucket predictor. Depends on tbp_pkg and the policer RTL.
module token_bucket_policer_test;
    import tbp_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CLIENT_W-1:0]  client;
    logic [TIME_W-1:0]    now_seconds;
    logic                 out_valid;
    logic                 out_ready;
    logic                 allowed;

    // Predictor state: one bucket per client slot plus the two limits.
    logic                 slot_used  [CLIENTS];
    logic [LEVEL_W-1:0]   slot_level [CLIENTS];
    logic [TIME_W-1:0]    slot_stamp [CLIENTS];
    logic [RATE_W-1:0]    rate_per_min;
    logic [BURST_W-1:0]   burst_tokens;

    // Decisions still owed by the block, oldest first.
    logic                 expected_allowed[$];
    logic                 want_allowed;
    int                   mismatch_count = 0;

    // Percent of cycles in which the sender idles or the receiver stalls.
    int                   send_idle_pct  = 26;
    int                   recv_stall_pct = 26;

    token_bucket_policer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .client       (client),
        .now_seconds  (now_seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .allowed      (allowed)
    );

    always #5 clk = ~clk;

    // Refill the bucket of one slot, then try to take one token from it.
    function automatic logic bucket_decision(input logic [CLIENT_W-1:0] slot,
                                             input logic [TIME_W-1:0] stamp);
        logic [63:0]       cap;
        logic [63:0]       level;
        logic [63:0]       elapsed;
        logic [SLOT_W-1:0] idx;
        idx = SLOT_W'(int'(slot) % CLIENTS);
        cap = 64'(burst_tokens) * 64'(UNITS_PER_TOKEN);
        if (slot_used[idx])
        begin
            elapsed = (stamp > slot_stamp[idx]) ? 64'(stamp - slot_stamp[idx]) : 64'd0;
            level = 64'(slot_level[idx]) + elapsed * 64'(rate_per_min);
            if (level > cap)
                level = cap;
        end
        else
        begin
            level = cap;
        end
        if (level >= 64'(UNITS_PER_TOKEN))
        begin
            level           = level - 64'(UNITS_PER_TOKEN);
            slot_level[idx] = level[LEVEL_W-1:0];
            slot_stamp[idx] = stamp;
            slot_used[idx]  = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Present one request, hold it until the transfer, then record the decision.
    task automatic send_request(input logic [CLIENT_W-1:0] slot,
                                input logic [TIME_W-1:0] stamp);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        client      <= slot;
        now_seconds <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_allowed.push_back(bucket_decision(slot, stamp));
    endtask

    // Stop sending and let every outstanding decision come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_allowed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_REG_RATE)
            rate_per_min = value;
        else
            burst_tokens = value;
        @(posedge clk);
    endtask

    // Reprogram both limits once the block has gone quiet.
    task automatic set_limits(input logic [RATE_W-1:0] rate, input logic [BURST_W-1:0] burst);
        wait_idle();
        write_register(CFG_REG_RATE, rate);
        write_register(CFG_REG_BURST, burst);
    endtask

    // Bursty traffic on a few hot slots with slowly moving time, plus noise.
    task automatic run_random_traffic(input int count);
        logic [CLIENT_W-1:0] hot_slots [4];
        logic [CLIENT_W-1:0] slot;
        logic [TIME_W-1:0]   clock_now;
        int                  pick;
        foreach (hot_slots[i])
            hot_slots[i] = CLIENT_W'($urandom_range(255));
        clock_now = $urandom();
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                clock_now = clock_now;
            else if (pick < 85)
                clock_now = clock_now + 1;
            else if (pick < 95)
                clock_now = clock_now + $urandom_range(2, 120);
            else if (pick < 98)
                clock_now = clock_now - $urandom_range(1, 300);
            else
                clock_now = $urandom();
            if ($urandom_range(99) < 75)
                slot = hot_slots[2'($urandom_range(3))];
            else
                slot = CLIENT_W'($urandom_range(255));
            send_request(slot, clock_now);
        end
    endtask

    // Fresh slots at both ends of the index and time ranges, time going
    // backwards and a refill large enough to saturate.
    task automatic test_fresh_and_time_edges();
        send_request(8'h00, 32'h0000_0000);
        send_request(8'hFF, 32'hFFFF_FFFF);
        send_request(8'hFF, 32'h0000_0000);
        send_request(8'h00, 32'hFFFF_FFFF);
    endtask

    // Drain a small bucket with no refill at all.
    task automatic test_zero_rate_drain();
        set_limits(16'd0, 16'd2);
        send_request(8'hA5, 32'd100);
        send_request(8'hA5, 32'd100);
        send_request(8'hA5, 32'd100);
        send_request(8'hA5, 32'd1000);
    endtask

    // A zero burst denies fresh slots and caps stored levels down to nothing.
    task automatic test_zero_burst();
        set_limits(16'd0, 16'd0);
        send_request(8'h5A, 32'd7);
        send_request(8'h00, 32'hFFFF_FFFF);
    endtask

    // One token per minute: a refill one unit short must still be denied.
    task automatic test_refill_boundary();
        set_limits(16'd1, 16'd1);
        send_request(8'h03, 32'd5);
        send_request(8'h03, 32'd64);
        send_request(8'h03, 32'd65);
        send_request(8'h03, 32'd65);
    endtask

    // Largest rate and burst with a full-range elapsed time.
    task automatic test_max_limits();
        set_limits(16'hFFFF, 16'hFFFF);
        send_request(8'h00, 32'h0000_0001);
        send_request(8'hA5, 32'hFFFF_FFFF);
        send_request(8'h03, 32'h8000_0000);
    endtask

    // Random traffic under a range of limit settings, extremes included.
    task automatic test_random_settings();
        logic [RATE_W-1:0]  rates  [6] = '{16'd600, 16'd0, 16'hFFFF, 16'd1, 16'd60, 16'd0};
        logic [BURST_W-1:0] bursts [6] = '{16'd50, 16'd3, 16'hFFFF, 16'd1, 16'd4, 16'd0};
        rates[5]  = RATE_W'($urandom_range(0, 65535));
        bursts[5] = BURST_W'($urandom_range(0, 20));
        for (int p = 0; p < 6; p++)
        begin
            set_limits(rates[p], bursts[p]);
            run_random_traffic(190);
        end
    endtask

    // A stretch with neither sender gaps nor receiver stalls.
    task automatic test_back_to_back();
        set_limits(RATE_RESET, 16'd5);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_traffic(120);
        wait_idle();
        send_idle_pct  = 26;
        recv_stall_pct = 26;
    endtask

    // Compare every result transfer with the oldest pending decision.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_allowed.size() == 0)
            begin
                $error("allowed: expected none, actual %0b", allowed);
                mismatch_count++;
            end
            else
            begin
                want_allowed = expected_allowed.pop_front();
                if (allowed !== want_allowed)
                begin
                    $error("allowed: expected %0b, actual %0b", want_allowed, allowed);
                    mismatch_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Main sequence.
    initial
    begin
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= CFG_REG_RATE;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        client       <= '0;
        now_seconds  <= '0;
        rate_per_min = RATE_RESET;
        burst_tokens = BURST_RESET;
        foreach (slot_used[i])
        begin
            slot_used[i]  = 1'b0;
            slot_level[i] = '0;
            slot_stamp[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fresh_and_time_edges();
        test_zero_rate_drain();
        test_zero_burst();
        test_refill_boundary();
        test_max_limits();
        test_random_settings();
        test_back_to_back();

        wait_idle();
        if (mismatch_count == 0 && expected_allowed.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tbp_pkg.sv
rtl/core/tbp_ram.sv
rtl/core/tbp_ctrl.sv
rtl/core/tbp_dp.sv
rtl/core/token_bucket_policer.sv
tb/token_bucket_policer_test.sv
